// File: rtl/solve_3x3_linear_system_unit_assert.svh
// Assertion macros shared by the solver RTL.
`ifndef SOLVE_3X3_LINEAR_SYSTEM_UNIT_ASSERT_SVH
`define SOLVE_3X3_LINEAR_SYSTEM_UNIT_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define S3LS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("solver assertion failed");

// Check that a condition never holds outside reset.
`define S3LS_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("solver forbidden condition seen");

`endif

// File: rtl/s3ls_pkg.sv
// Package: widths, lane types and arithmetic helpers of the 3x3 solver.
package s3ls_pkg;

    localparam int IN_WIDTH = 16;
    localparam int OUT_W    = 32;
    localparam int OUT_FRAC = 16;
    localparam int PW       = 2 * IN_WIDTH;
    localparam int CW       = PW + 1;
    localparam int TW       = CW + IN_WIDTH;
    localparam int SW       = TW + 2;
    localparam int QW       = OUT_W + 1;
    localparam int QSH      = QW - OUT_FRAC;
    localparam int NST      = 7 + QW;

    // Operand pairs of the nine adjugate entries, row-major matrix index.
    localparam logic [3:0] PIDX [0:35] = '{
        4'd4, 4'd8, 4'd5, 4'd7,
        4'd2, 4'd7, 4'd1, 4'd8,
        4'd1, 4'd5, 4'd2, 4'd4,
        4'd5, 4'd6, 4'd3, 4'd8,
        4'd0, 4'd8, 4'd2, 4'd6,
        4'd2, 4'd3, 4'd0, 4'd5,
        4'd3, 4'd7, 4'd4, 4'd6,
        4'd1, 4'd6, 4'd0, 4'd7,
        4'd0, 4'd4, 4'd1, 4'd3
    };

    typedef struct packed {
        logic [SW-1:0] rem;
        logic [QW-1:0] low;
        logic [QW-1:0] quo;
        logic          neg;
        logic          ov;
    } lane_t;

    typedef struct packed {
        lane_t [2:0]   ln;
        logic [SW-1:0] dmag;
        logic          sing;
    } dstg_t;

    // One restoring division step: shift in a bit, subtract when it fits.
    function automatic lane_t div_step(lane_t l, logic [SW-1:0] d);
        logic [SW:0] t;
        logic [SW:0] diff;
        logic        ge;
        lane_t       r;
        t      = {l.rem, l.low[QW-1]};
        diff   = t - {1'b0, d};
        ge     = (t >= {1'b0, d});
        r      = l;
        r.rem  = ge ? diff[SW-1:0] : t[SW-1:0];
        r.low  = {l.low[QW-2:0], 1'b0};
        r.quo  = {l.quo[QW-2:0], ge};
        return r;
    endfunction

    // Apply sign and saturate the magnitude quotient to Q16.16.
    function automatic logic [OUT_W-1:0] sat_out(lane_t l);
        logic [QW-1:0] pmax;
        logic [QW-1:0] nmax;
        logic [QW-1:0] negq;
        pmax = {2'b00, {(OUT_W-1){1'b1}}};
        nmax = {2'b01, {(OUT_W-1){1'b0}}};
        negq = -l.quo;
        if (l.neg)
            return (l.ov || l.quo > nmax) ? nmax[OUT_W-1:0] : negq[OUT_W-1:0];
        return (l.ov || l.quo > pmax) ? pmax[OUT_W-1:0] : l.quo[OUT_W-1:0];
    endfunction

endpackage

// File: rtl/solve_3x3_linear_system_unit.sv
// Top level: pipelined 3x3 linear system solver by Cramer's rule.
//
//  channel | handshake          | payload
//  --------+--------------------+-------------------------------------------
//  in      | in_valid, in_stall | a11..a33, rhs1..rhs3 (signed Q8.8)
//  out     | out_valid,out_stall| sol_x, sol_y, sol_z (Q16.16), singular
//
// One system enters per cycle while in_stall is low; each system passes input
// capture, four arithmetic stages, one prep stage, 33 divider stages of one
// quotient bit each and one saturate stage (40 registers) before out_valid rises.
// Throughput is one system per cycle while the output is not stalled; the divider lanes set most of the latency.
// Reset clears only the stage valid bits; payload registers are free.
// A stall on the output freezes only the stages that are full behind it,
// so bubbles are squeezed out and nothing is lost or repeated.
module solve_3x3_linear_system_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [s3ls_pkg::IN_WIDTH-1:0] a11,
    input  logic signed [s3ls_pkg::IN_WIDTH-1:0] a12,
    input  logic signed [s3ls_pkg::IN_WIDTH-1:0] a13,
    input  logic signed [s3ls_pkg::IN_WIDTH-1:0] a21,
    input  logic signed [s3ls_pkg::IN_WIDTH-1:0] a22,
    input  logic signed [s3ls_pkg::IN_WIDTH-1:0] a23,
    input  logic signed [s3ls_pkg::IN_WIDTH-1:0] a31,
    input  logic signed [s3ls_pkg::IN_WIDTH-1:0] a32,
    input  logic signed [s3ls_pkg::IN_WIDTH-1:0] a33,
    input  logic signed [s3ls_pkg::IN_WIDTH-1:0] rhs1,
    input  logic signed [s3ls_pkg::IN_WIDTH-1:0] rhs2,
    input  logic signed [s3ls_pkg::IN_WIDTH-1:0] rhs3,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [s3ls_pkg::OUT_W-1:0]    sol_x,
    output logic signed [s3ls_pkg::OUT_W-1:0]    sol_y,
    output logic signed [s3ls_pkg::OUT_W-1:0]    sol_z,
    output logic                                singular
);
    import s3ls_pkg::*;

    `include "solve_3x3_linear_system_unit_assert.svh"

    logic [NST-1:0] vld_reg;
    logic [NST-1:0] ce;

    // Stage 0: captured inputs.
    logic signed [IN_WIDTH-1:0] a_reg [0:8];
    logic signed [IN_WIDTH-1:0] b_reg [0:2];
    // Stage 1: pair products.
    logic signed [PW-1:0]       p_reg [0:17];
    logic signed [IN_WIDTH-1:0] ra1_reg [0:2];
    logic signed [IN_WIDTH-1:0] b1_reg [0:2];
    // Stage 2: adjugate entries.
    logic signed [CW-1:0]       c_reg [0:8];
    logic signed [IN_WIDTH-1:0] ra2_reg [0:2];
    logic signed [IN_WIDTH-1:0] b2_reg [0:2];
    // Stage 3: entry times coefficient or rhs.
    logic signed [TW-1:0]       t_reg [0:11];
    // Stage 4: determinant and numerators.
    logic signed [SW-1:0]       det_reg;
    logic signed [SW-1:0]       n_reg [0:2];
    // Stage 5 .. 5+QW: divider pipeline.
    dstg_t                      dv_reg [0:QW];
    dstg_t                      dv_next;
    // Output register.
    logic [OUT_W-1:0]           x_reg, y_reg, z_reg;
    logic                       sing_reg;

    // Advance a stage when it is empty or the stage after it advances.
    always_comb
    begin
        ce[NST-1] = !vld_reg[NST-1] || !out_stall;
        for (int i = NST - 2; i >= 0; i--)
            ce[i] = !vld_reg[i] || ce[i+1];
    end

    assign in_stall = !ce[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (ce[0])
                vld_reg[0] <= in_valid;
            for (int i = 1; i < NST; i++)
                if (ce[i])
                    vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce[0])
        begin
            a_reg[0] <= a11; a_reg[1] <= a12; a_reg[2] <= a13;
            a_reg[3] <= a21; a_reg[4] <= a22; a_reg[5] <= a23;
            a_reg[6] <= a31; a_reg[7] <= a32; a_reg[8] <= a33;
            b_reg[0] <= rhs1; b_reg[1] <= rhs2; b_reg[2] <= rhs3;
        end
        if (ce[1])
        begin
            for (int k = 0; k < 18; k++)
                p_reg[k] <= PW'(a_reg[PIDX[2*k]] * a_reg[PIDX[2*k+1]]);
            for (int k = 0; k < 3; k++)
            begin
                ra1_reg[k] <= a_reg[k];
                b1_reg[k]  <= b_reg[k];
            end
        end
        if (ce[2])
        begin
            for (int k = 0; k < 9; k++)
                c_reg[k] <= CW'(p_reg[2*k]) - CW'(p_reg[2*k+1]);
            for (int k = 0; k < 3; k++)
            begin
                ra2_reg[k] <= ra1_reg[k];
                b2_reg[k]  <= b1_reg[k];
            end
        end
        if (ce[3])
        begin
            // Determinant by expansion along row one.
            for (int k = 0; k < 3; k++)
                t_reg[k] <= TW'(c_reg[3*k] * ra2_reg[k]);
            // Numerator j, term i: adjugate row j times rhs element i.
            for (int j = 0; j < 3; j++)
                for (int i = 0; i < 3; i++)
                    t_reg[3+3*j+i] <= TW'(c_reg[3*j+i] * b2_reg[i]);
        end
        if (ce[4])
        begin
            det_reg <= SW'(t_reg[0]) + SW'(t_reg[1]) + SW'(t_reg[2]);
            for (int j = 0; j < 3; j++)
                n_reg[j] <= SW'(t_reg[3+3*j]) + SW'(t_reg[4+3*j]) + SW'(t_reg[5+3*j]);
        end
        if (ce[5])
            dv_reg[0] <= dv_next;
        for (int k = 1; k <= QW; k++)
        begin
            if (ce[5+k])
            begin
                dv_reg[k].dmag <= dv_reg[k-1].dmag;
                dv_reg[k].sing <= dv_reg[k-1].sing;
                for (int j = 0; j < 3; j++)
                    dv_reg[k].ln[j] <= div_step(dv_reg[k-1].ln[j], dv_reg[k-1].dmag);
            end
        end
        if (ce[NST-1])
        begin
            sing_reg <= dv_reg[QW].sing;
            x_reg    <= dv_reg[QW].sing ? '0 : sat_out(dv_reg[QW].ln[0]);
            y_reg    <= dv_reg[QW].sing ? '0 : sat_out(dv_reg[QW].ln[1]);
            z_reg    <= dv_reg[QW].sing ? '0 : sat_out(dv_reg[QW].ln[2]);
        end
    end

    // Prep: take magnitudes, flag overflow, load the divider remainders.
    always_comb
    begin
        logic [SW-1:0] dmag;
        logic [SW-1:0] nmag;
        dmag          = det_reg[SW-1] ? SW'(-det_reg) : SW'(det_reg);
        dv_next.dmag  = dmag;
        dv_next.sing  = (det_reg == '0);
        for (int j = 0; j < 3; j++)
        begin
            nmag = n_reg[j][SW-1] ? SW'(-n_reg[j]) : SW'(n_reg[j]);
            dv_next.ln[j].neg = n_reg[j][SW-1] ^ det_reg[SW-1];
            dv_next.ln[j].ov  = ((nmag >> QSH) >= dmag);
            dv_next.ln[j].rem = nmag >> QSH;
            dv_next.ln[j].low = {nmag[QSH-1:0], {OUT_FRAC{1'b0}}};
            dv_next.ln[j].quo = '0;
        end
    end

    assign out_valid = vld_reg[NST-1];
    assign sol_x     = x_reg;
    assign sol_y     = y_reg;
    assign sol_z     = z_reg;
    assign singular  = sing_reg;

    `S3LS_ASSERT(a_accept_lands, (in_valid && !in_stall) |=> vld_reg[0])
    `S3LS_ASSERT(a_stall_full, in_stall |-> (out_valid && out_stall))
    `S3LS_ASSERT(a_sing_zero, (out_valid && singular) |-> (sol_x == 0 && sol_y == 0 && sol_z == 0))
    `S3LS_NEVER(a_no_overwrite, vld_reg[NST-1] && out_stall && ce[NST-1])

endmodule

// File: tb/sv/tb_solve_3x3_linear_system_unit.sv
// Testbench for the 3x3 Cramer's rule solver: directed, random and backpressure tests.
module tb_solve_3x3_linear_system_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import s3ls_pkg::*;

    localparam int LATENCY     = 40;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_LEN    = 150;

    typedef logic signed [IN_WIDTH-1:0] coef_t;
    typedef logic signed [127:0]        big_t;

    typedef struct {
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
        logic signed [OUT_W-1:0] z;
        logic                    sing;
    } solution_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    coef_t a11, a12, a13, a21, a22, a23, a31, a32, a33, rhs1, rhs2, rhs3;
    logic out_valid;
    logic out_stall;
    logic signed [OUT_W-1:0] sol_x, sol_y, sol_z;
    logic singular;

    solution_t pending_solutions[$];
    int        mismatches;
    int        cycle_count;
    int        tx_idle_pct;
    int        rx_idle_pct;
    int        hold_left;
    bit        hold_req;

    solve_3x3_linear_system_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .a11       (a11),
        .a12       (a12),
        .a13       (a13),
        .a21       (a21),
        .a22       (a22),
        .a23       (a23),
        .a31       (a31),
        .a32       (a32),
        .a33       (a33),
        .rhs1      (rhs1),
        .rhs2      (rhs2),
        .rhs3      (rhs3),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sol_x     (sol_x),
        .sol_y     (sol_y),
        .sol_z     (sol_z),
        .singular  (singular)
    );

    // 2 ns clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Truncating quotient of a Q16.16 scaled numerator, saturated to 32 bits.
    function automatic logic signed [OUT_W-1:0] cramer_quotient(big_t num, big_t det);
        big_t q;
        q = (num * big_t'(65536)) / det;
        if (q > big_t'(64'sd2147483647))
            return 32'h7FFF_FFFF;
        if (q < -big_t'(64'sd2147483648))
            return 32'h8000_0000;
        return q[OUT_W-1:0];
    endfunction

    // Solve one system exactly; m is the matrix row-major, b the right-hand side.
    function automatic solution_t solve_system(coef_t m[9], coef_t b[3]);
        big_t      w[9];
        big_t      v[3];
        big_t      det, nx, ny, nz;
        solution_t s;
        for (int i = 0; i < 9; i++)
            w[i] = m[i];
        for (int i = 0; i < 3; i++)
            v[i] = b[i];
        det = w[0]*w[4]*w[8] + w[6]*w[1]*w[5] + w[2]*w[3]*w[7]
            - w[2]*w[4]*w[6] - w[0]*w[5]*w[7] - w[8]*w[3]*w[1];
        if (det == 0)
        begin
            s.x = '0;
            s.y = '0;
            s.z = '0;
            s.sing = 1'b1;
            return s;
        end
        nx = (w[4]*w[8] - w[5]*w[7]) * v[0] + (w[2]*w[7] - w[1]*w[8]) * v[1]
           + (w[1]*w[5] - w[2]*w[4]) * v[2];
        ny = (w[5]*w[6] - w[3]*w[8]) * v[0] + (w[0]*w[8] - w[2]*w[6]) * v[1]
           + (w[2]*w[3] - w[0]*w[5]) * v[2];
        nz = (w[3]*w[7] - w[4]*w[6]) * v[0] + (w[1]*w[6] - w[0]*w[7]) * v[1]
           + (w[0]*w[4] - w[1]*w[3]) * v[2];
        s.x = cramer_quotient(nx, det);
        s.y = cramer_quotient(ny, det);
        s.z = cramer_quotient(nz, det);
        s.sing = 1'b0;
        return s;
    endfunction

    // Offer one system, idling each cycle at the current sender rate; hold until accepted.
    task automatic send_system(coef_t m[9], coef_t b[3]);
        while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        a11 <= m[0]; a12 <= m[1]; a13 <= m[2];
        a21 <= m[3]; a22 <= m[4]; a23 <= m[5];
        a31 <= m[6]; a32 <= m[7]; a33 <= m[8];
        rhs1 <= b[0]; rhs2 <= b[1]; rhs3 <= b[2];
        do
            @(posedge clk);
        while (in_stall);
        pending_solutions.push_back(solve_system(m, b));
    endtask

    // Drop the valid and wait until every expected beat has come back.
    task automatic drain_pipeline();
        in_valid <= 1'b0;
        wait (pending_solutions.size() == 0);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    // Receiver stall: random at rx_idle_pct, or a long hold-off on request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_req && hold_left == 0)
        begin
            hold_req  <= 1'b0;
            hold_left <= HOLD_LEN;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= (hold_left > 1);
        end
        else
        begin
            out_stall <= (rx_idle_pct > 0 && $urandom_range(99) < rx_idle_pct);
        end
    end

    // Compare every accepted output beat with the oldest expected solution.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            solution_t e;
            if (pending_solutions.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected output beat x=%h y=%h z=%h sing=%b",
                             sol_x, sol_y, sol_z, singular);
            end
            else
            begin
                e = pending_solutions.pop_front();
                if (sol_x !== e.x || sol_y !== e.y || sol_z !== e.z || singular !== e.sing)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: exp x=%h y=%h z=%h sing=%b got x=%h y=%h z=%h sing=%b",
                                 e.x, e.y, e.z, e.sing, sol_x, sol_y, sol_z, singular);
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Random coefficient: mostly full range, sometimes small, sometimes extreme.
    function automatic coef_t rand_coef();
        case ($urandom_range(9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2, 3, 4: return coef_t'($signed($urandom_range(1024)) - 512);
            default: return coef_t'($urandom);
        endcase
    endfunction

    // Fill a random system; some are made singular by a dependent third row.
    task automatic make_system(output coef_t m[9], output coef_t b[3]);
        for (int i = 0; i < 9; i++)
            m[i] = rand_coef();
        for (int i = 0; i < 3; i++)
            b[i] = rand_coef();
        case ($urandom_range(9))
            0:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    m[i]     = coef_t'($signed($urandom_range(2000)) - 1000);
                    m[3 + i] = coef_t'($signed($urandom_range(2000)) - 1000);
                    m[6 + i] = m[i] + m[3 + i];
                end
            end
            1:
            begin
                // near-singular: tiny determinant drives saturation
                for (int i = 0; i < 9; i++)
                    m[i] = coef_t'($urandom_range(2));
            end
            default: ;
        endcase
    endtask

    task automatic test_directed();
        coef_t m[9];
        coef_t b[3];
        // identity with extreme rhs
        m = '{16'sh0100, 0, 0, 0, 16'sh0100, 0, 0, 0, 16'sh0100};
        b = '{16'sh7FFF, 16'sh8000, 16'sh0001};
        send_system(m, b);
        // zero matrix: singular
        m = '{default: 0};
        b = '{16'sh0100, 16'sh0200, 16'sh0300};
        send_system(m, b);
        // all most-negative: equal rows, singular
        m = '{default: 16'sh8000};
        b = '{default: 16'sh8000};
        send_system(m, b);
        // all most-positive: singular
        m = '{default: 16'sh7FFF};
        b = '{default: 16'sh7FFF};
        send_system(m, b);
        // smallest step on diagonal with largest rhs: largest and most-negative outputs
        m = '{16'sh0001, 0, 0, 0, 16'sh0001, 0, 0, 0, 16'sh0001};
        b = '{16'sh7FFF, 16'sh8000, 16'sh0000};
        send_system(m, b);
        // negative diagonal: sign flips
        m = '{16'shFFFF, 0, 0, 0, 16'shFF00, 0, 0, 0, 16'sh8000};
        b = '{16'sh0001, 16'sh7FFF, 16'sh8000};
        send_system(m, b);
        // exact quotients of both signs, then inexact ones from extreme coefficients
        m = '{16'sh0300, 16'sh0100, 0, 0, 16'sh0300, 16'sh0100, 16'sh0100, 0, 16'sh0300};
        b = '{16'sh0100, 16'shFF00, 16'sh0200};
        send_system(m, b);
        m = '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000,
              16'sh0001, 16'shFFFF, 16'sh0002};
        b = '{16'sh5555, 16'shAAAA, 16'sh0F0F};
        send_system(m, b);
        // zero rhs, regular matrix
        m = '{0, 16'sh0100, 0, 16'sh0100, 0, 0, 0, 0, 16'shFF00};
        b = '{default: 0};
        send_system(m, b);
        drain_pipeline();
    endtask

    task automatic test_random(int count);
        coef_t m[9];
        coef_t b[3];
        for (int n = 0; n < count; n++)
        begin
            make_system(m, b);
            send_system(m, b);
        end
        drain_pipeline();
    endtask

    // Long receiver hold-off while the sender keeps offering, then a drain and a further burst.
    task automatic test_backpressure();
        coef_t m[9];
        coef_t b[3];
        hold_req = 1'b1;
        for (int n = 0; n < 80; n++)
        begin
            make_system(m, b);
            send_system(m, b);
        end
        drain_pipeline();
        for (int n = 0; n < 20; n++)
        begin
            make_system(m, b);
            send_system(m, b);
        end
        drain_pipeline();
    endtask

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        {a11, a12, a13, a21, a22, a23, a31, a32, a33} = '0;
        {rhs1, rhs2, rhs3} = '0;
        mismatches  = 0;
        cycle_count = 0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req    = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();

        // sender idles lightly, receiver heavily; then swap; then full rate
        tx_idle_pct = 28;
        rx_idle_pct = 52;
        test_random(170);
        tx_idle_pct = 52;
        rx_idle_pct = 28;
        test_random(170);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random(170);

        test_backpressure();

        if (mismatches == 0 && pending_solutions.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
